### sv/awd_pkg.sv
// ----------------------------------------------------------------------------
// awd_pkg - shared constants, types and tables of the waveshaper
// Sample format, register codes, exponential tables (built at elaboration)
// and the stage-enable group handed to the exponential unit.
// ----------------------------------------------------------------------------
package awd_pkg;

    // Sample format: Q1.(SAMPLE_BITS-1), full scale 1.0 = 2^FB
    localparam int SAMPLE_BITS = 24;
    localparam int FB          = SAMPLE_BITS - 1;

    // Gain register formats
    localparam int DRIVE_W   = 23;
    localparam int LEVEL_W   = 20;
    localparam int MODE_W    = 3;
    localparam int GAIN_FRAC = 16;

    // Driven magnitude: up to about 128 x full scale
    localparam int M_W = SAMPLE_BITS + 7;

    // Configuration port
    localparam int CFG_DATA_W = DRIVE_W;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPER_MODE  = 2'd2;

    localparam logic [DRIVE_W-1:0] DRIVE_GAIN_RST   = 23'd207243;
    localparam logic [LEVEL_W-1:0] OUTPUT_LEVEL_RST = 20'd65536;

    // Shaper codes
    localparam logic [MODE_W-1:0] MODE_HARD      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUAD      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXP       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FULL_RECT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HALF_RECT = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RST       = MODE_HARD;

    // Exponential tables, Q1.30
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_FRAC_BITS   = 30;
    localparam int EXP_W           = EXP_FRAC_BITS + 1;
    localparam int IPOW_N          = 32;
    localparam int IPOW_W          = $clog2(IPOW_N);
    localparam int JW              = $clog2(EXP_TABLE_DEPTH);
    localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int KW              = M_W - FB;

    typedef logic [EXP_W-1:0] t_exp_frac [0:EXP_TABLE_DEPTH];
    typedef logic [EXP_W-1:0] t_exp_int  [0:IPOW_N-1];

    // Stage enables for the exponential unit (stages 3 to 7)
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
        logic en7;
    } t_exp_ctl;

    // Shift-subtract long division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-(j/DEPTH): 1 / series of e^(j/DEPTH), rounded
    function automatic t_exp_frac build_exp_frac();
        t_exp_frac   tab;
        logic [63:0] term;
        logic [63:0] sum;
        for (int j = 0; j <= EXP_TABLE_DEPTH; j++) begin
            term = 64'd1 << 32;
            sum  = term;
            for (int n = 1; n < 40; n++) begin
                if (term != 64'd0) begin
                    term = udiv64(term * 64'(j), 64'(EXP_TABLE_DEPTH) * 64'(n));
                    sum  = sum + term;
                end
            end
            tab[j] = EXP_W'(udiv64((64'd1 << 62) + (sum >> 1), sum));
        end
        return tab;
    endfunction

    // e^-k by repeated rounded multiplication by e^-1
    function automatic t_exp_int build_exp_int(input t_exp_frac fr);
        t_exp_int tab;
        logic [63:0] acc;
        tab[0] = EXP_W'(64'd1 << EXP_FRAC_BITS);
        for (int k = 1; k < IPOW_N; k++) begin
            acc    = 64'(tab[k-1]) * 64'(fr[EXP_TABLE_DEPTH]) + (64'd1 << (EXP_FRAC_BITS - 1));
            tab[k] = EXP_W'(acc >> EXP_FRAC_BITS);
        end
        return tab;
    endfunction

    localparam t_exp_frac EXP_FRAC = build_exp_frac();
    localparam t_exp_int  EXP_INT  = build_exp_int(EXP_FRAC);

endpackage

### sv/awd_in_if.sv
// ----------------------------------------------------------------------------
// awd_in_if - sample input channel
// Valid/ready handshake carrying one signed audio sample per item.
// ----------------------------------------------------------------------------
interface awd_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [awd_pkg::SAMPLE_BITS-1:0]   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

### sv/awd_out_if.sv
// ----------------------------------------------------------------------------
// awd_out_if - shaped sample output channel
// Valid/ready handshake carrying the shaped sample and its saturation flag.
// ----------------------------------------------------------------------------
interface awd_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [awd_pkg::SAMPLE_BITS-1:0]   sample_out;
    logic                                     saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

### sv/awd_exp.sv
// ----------------------------------------------------------------------------
// awd_exp - exponential soft clip, 1 - e^-m
// Five register stages: table lookup, interpolation multiply, interpolation
// round, integer-part multiply, final round and scale to full scale.
// ----------------------------------------------------------------------------
module awd_exp (
    input  logic                            i_clk,
    input  awd_pkg::t_exp_ctl               i_ctl,
    input  logic [awd_pkg::M_W-1:0]         i_m,
    output logic [awd_pkg::SAMPLE_BITS-1:0] o_ye
);
    localparam int SB     = awd_pkg::SAMPLE_BITS;
    localparam int FB     = awd_pkg::FB;
    localparam int EXP_W  = awd_pkg::EXP_W;
    localparam int EFB    = awd_pkg::EXP_FRAC_BITS;
    localparam int JW     = awd_pkg::JW;
    localparam int IDX_W  = awd_pkg::IDX_W;
    localparam int KW     = awd_pkg::KW;
    localparam int IPOW_W = awd_pkg::IPOW_W;
    localparam int POS_W  = FB + JW;
    localparam int DW_W   = EXP_W + FB;
    localparam int EP_W   = 2 * EXP_W;
    localparam logic [SB-1:0] FULL = {1'b1, {FB{1'b0}}};

    // stage 3: split m, look up neighbors
    logic [KW-1:0]    w_k;
    logic [FB-1:0]    w_r;
    logic [POS_W-1:0] w_pos;
    logic [IDX_W-1:0] w_j0;
    logic [IDX_W-1:0] w_j1;
    logic [EXP_W-1:0] w_fa;
    logic [EXP_W-1:0] w_fb;

    logic [EXP_W-1:0]  r3_fa;
    logic [EXP_W-1:0]  r3_diff;
    logic [FB-1:0]     r3_w;
    logic [IPOW_W-1:0] r3_k;
    logic              r3_big;

    logic [DW_W-1:0]   r4_dw;
    logic [EXP_W-1:0]  r4_fa;
    logic [IPOW_W-1:0] r4_k;
    logic              r4_big;

    logic [EXP_W-1:0]  n5_v;
    logic [DW_W:0]     w_dw_rnd;
    logic [EXP_W-1:0]  r5_v;
    logic [IPOW_W-1:0] r5_k;
    logic              r5_big;

    logic [EP_W-1:0]   r6_ep;
    logic              r6_big;

    logic [EP_W:0]     w_ep_rnd;
    logic [EXP_W-1:0]  w_e;
    logic [DW_W:0]     w_sc_rnd;
    logic [SB-1:0]     n7_ye;
    logic [SB-1:0]     r7_ye;

    // r is below 1.0, so j stays below the last entry
    always_comb begin
        w_k   = i_m[FB +: KW];
        w_r   = i_m[FB-1:0];
        w_pos = POS_W'(w_r) * POS_W'(awd_pkg::EXP_TABLE_DEPTH);
        w_j0  = IDX_W'(w_pos[FB +: JW]);
        w_j1  = w_j0 + IDX_W'(1);
        w_fa  = awd_pkg::EXP_FRAC[w_j0];
        w_fb  = awd_pkg::EXP_FRAC[w_j1];
    end

    // interpolation round
    always_comb begin
        w_dw_rnd = {1'b0, r4_dw} + (DW_W+1)'(64'd1 << (FB - 1));
        n5_v     = r4_fa - w_dw_rnd[FB +: EXP_W];
    end

    // e = e^-k * v, then y = F - e * F
    always_comb begin
        w_ep_rnd = {1'b0, r6_ep} + (EP_W+1)'(64'd1 << (EFB - 1));
        w_e      = r6_big ? '0 : w_ep_rnd[EFB +: EXP_W];
        w_sc_rnd = {1'b0, w_e, {FB{1'b0}}} + (DW_W+1)'(64'd1 << (EFB - 1));
        n7_ye    = FULL - w_sc_rnd[EFB +: SB];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r3_fa   <= w_fa;
            r3_diff <= w_fa - w_fb;
            r3_w    <= w_pos[FB-1:0];
            r3_k    <= w_k[IPOW_W-1:0];
            r3_big  <= |w_k[KW-1:IPOW_W];
        end
        if (i_ctl.en4) begin
            r4_dw  <= DW_W'(r3_diff) * DW_W'(r3_w);
            r4_fa  <= r3_fa;
            r4_k   <= r3_k;
            r4_big <= r3_big;
        end
        if (i_ctl.en5) begin
            r5_v   <= n5_v;
            r5_k   <= r4_k;
            r5_big <= r4_big;
        end
        if (i_ctl.en6) begin
            r6_ep  <= EP_W'(awd_pkg::EXP_INT[r5_k]) * EP_W'(r5_v);
            r6_big <= r5_big;
        end
        if (i_ctl.en7) begin
            r7_ye <= n7_ye;
        end
    end

    assign o_ye = r7_ye;

endmodule

### sv/audio_waveshaper_distortion.sv
// ----------------------------------------------------------------------------
// audio_waveshaper_distortion - drive, waveshape, level, saturate
// Nine-stage pipeline: |x| * drive, five shapers, * level, round and clamp.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  i_in      in         valid / ready    sample_in  (24 b signed)
//  o_out     out        valid / ready    sample_out (24 b signed), saturated
//  i_cfg_*   in         write enable     i_cfg_idx (2 b), i_cfg_data (23 b)
//
//  One item per clock sustained while o_out.ready does not stall the output.
//  The depth is set by the knee path (square, reciprocal divide by 3) and the
//  exponential path (interpolation multiply, integer-power multiply).
//  Reset clears all valid bits and loads the default gains and hard clip.
//  Each stage holds only when the next one is full, so bubbles close up
//  during an output stall and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module audio_waveshaper_distortion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    awd_in_if.sink                              i_in,
    awd_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [awd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [awd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int SB      = awd_pkg::SAMPLE_BITS;
    localparam int FB      = awd_pkg::FB;
    localparam int M_W     = awd_pkg::M_W;
    localparam int GF      = awd_pkg::GAIN_FRAC;
    localparam int PRODM_W = SB + awd_pkg::DRIVE_W;
    localparam int PRODL_W = M_W + awd_pkg::LEVEL_W;
    localparam int P_W     = PRODL_W + 1 - GF;
    localparam int S3      = SB | 1;
    localparam int QR_W    = SB + S3;
    localparam int DD_W    = 2 * FB;
    localparam logic [SB-1:0]    FULL      = {1'b1, {FB{1'b0}}};
    localparam logic [SB-1:0]    FULL_M1   = {1'b0, {FB{1'b1}}};
    localparam logic [M_W+1:0]   Q_ONE     = (M_W+2)'(FULL);
    localparam logic [M_W+1:0]   Q_TWO     = Q_ONE << 1;
    localparam logic [S3-1:0]    QUAD_RECIP = S3'(((64'd1 << S3) + 64'd1) / 64'd3);

    typedef enum logic [1:0] {
        Q_LIN,
        Q_KNEE,
        Q_TOP
    } t_qseg;

    // configuration registers
    logic [awd_pkg::DRIVE_W-1:0] r_drive_gain;
    logic [awd_pkg::LEVEL_W-1:0] r_output_level;
    logic [awd_pkg::MODE_W-1:0]  r_shaper_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_gain   <= awd_pkg::DRIVE_GAIN_RST;
            r_output_level <= awd_pkg::OUTPUT_LEVEL_RST;
            r_shaper_mode  <= awd_pkg::MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                awd_pkg::CFG_DRIVE_GAIN: begin
                    r_drive_gain <= i_cfg_data;
                end
                awd_pkg::CFG_OUTPUT_LEVEL: begin
                    r_output_level <= i_cfg_data[awd_pkg::LEVEL_W-1:0];
                end
                awd_pkg::CFG_SHAPER_MODE: begin
                    r_shaper_mode <= i_cfg_data[awd_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    logic [9:1] w_en;
    logic [8:1] r_vld;
    logic       r_out_valid;

    always_comb begin
        w_en[9] = !r_out_valid || o_out.ready;
        for (int i = 8; i >= 1; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign i_in.ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int i = 2; i <= 8; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
            if (w_en[9]) begin
                r_out_valid <= r_vld[8];
            end
        end
    end

    // stage 1: magnitude times drive
    logic [SB-1:0]      w_raw;
    logic [SB-1:0]      w_mag;
    logic [PRODM_W-1:0] r1_prod;
    logic               r1_neg;

    assign w_raw = i_in.sample_in;
    assign w_mag = w_raw[SB-1] ? (~w_raw + SB'(1)) : w_raw;

    // stage 2: round to driven magnitude
    logic [PRODM_W:0] w_m_rnd;
    logic [M_W-1:0]   r2_m;
    logic             r2_neg;

    assign w_m_rnd = {1'b0, r1_prod} + (PRODM_W+1)'(64'd1 << (GF - 1));

    // magnitude and sign delay line, stages 3 to 7
    logic [M_W-1:0] r_m_d [3:7];
    logic [7:3]     r_neg_d;

    // quadratic knee path
    logic [M_W+1:0] w_m3;
    t_qseg          n3_seg;
    logic [M_W+1:0] w_d;
    t_qseg          r3_seg;
    logic [FB-1:0]  r3_d;
    t_qseg          r4_seg;
    logic [DD_W-1:0] r4_dd;
    logic [DD_W:0]  w_dd_rnd;
    t_qseg          r5_seg;
    logic [QR_W-1:0] r5_qr;
    logic [SB-1:0]  n6_yq;
    logic [SB-1:0]  r6_yq;
    logic [SB-1:0]  r7_yq;

    // segment select on 3m against 1.0 and 2.0
    always_comb begin
        w_m3 = {1'b0, r2_m, 1'b0} + {2'b00, r2_m};
        w_d  = Q_TWO - w_m3;
        if (w_m3 > Q_TWO) begin
            n3_seg = Q_TOP;
        end else if (w_m3 > Q_ONE) begin
            n3_seg = Q_KNEE;
        end else begin
            n3_seg = Q_LIN;
        end
    end

    // round d^2 / F, then divide by 3 through the reciprocal
    assign w_dd_rnd = {1'b0, r4_dd} + (DD_W+1)'(64'd3 << (FB - 1));

    always_comb begin
        case (r5_seg)
            Q_LIN: begin
                n6_yq = {r_m_d[5][SB-2:0], 1'b0};
            end
            Q_KNEE: begin
                n6_yq = FULL - r5_qr[S3 +: SB];
            end
            default: begin
                n6_yq = FULL;
            end
        endcase
    end

    // exponential path
    awd_pkg::t_exp_ctl w_exp_ctl;
    logic [SB-1:0]     w_ye;

    assign w_exp_ctl.en3 = w_en[3];
    assign w_exp_ctl.en4 = w_en[4];
    assign w_exp_ctl.en5 = w_en[5];
    assign w_exp_ctl.en6 = w_en[6];
    assign w_exp_ctl.en7 = w_en[7];

    awd_exp u_exp (
        .i_clk (i_clk),
        .i_ctl (w_exp_ctl),
        .i_m   (r2_m),
        .o_ye  (w_ye)
    );

    // stage 8: shaper select and output level multiply
    logic [M_W-1:0]     n8_y;
    logic               n8_yneg;
    logic [PRODL_W-1:0] r8_prod;
    logic               r8_yneg;

    always_comb begin
        case (r_shaper_mode)
            awd_pkg::MODE_HARD: begin
                n8_y    = (r_m_d[7] > M_W'(FULL)) ? M_W'(FULL) : r_m_d[7];
                n8_yneg = r_neg_d[7];
            end
            awd_pkg::MODE_QUAD: begin
                n8_y    = M_W'(r7_yq);
                n8_yneg = r_neg_d[7];
            end
            awd_pkg::MODE_EXP: begin
                n8_y    = M_W'(w_ye);
                n8_yneg = r_neg_d[7];
            end
            awd_pkg::MODE_FULL_RECT: begin
                n8_y    = r_m_d[7];
                n8_yneg = 1'b0;
            end
            awd_pkg::MODE_HALF_RECT: begin
                n8_y    = r_neg_d[7] ? '0 : r_m_d[7];
                n8_yneg = 1'b0;
            end
            default: begin
                n8_y    = '0;
                n8_yneg = 1'b0;
            end
        endcase
    end

    // stage 9: round, clamp to the sample range, apply sign
    logic [PRODL_W:0] w_p_rnd;
    logic [P_W-1:0]   w_p;
    logic [SB-1:0]    n9_sample;
    logic             n9_sat;
    logic [SB-1:0]    r_out_sample;
    logic             r_out_sat;

    always_comb begin
        w_p_rnd = {1'b0, r8_prod} + (PRODL_W+1)'(64'd1 << (GF - 1));
        w_p     = w_p_rnd[PRODL_W:GF];
        n9_sat  = 1'b0;
        if (r8_yneg && (w_p != '0)) begin
            if (w_p > P_W'(FULL)) begin
                n9_sample = FULL;
                n9_sat    = 1'b1;
            end else begin
                n9_sample = SB'(0) - w_p[SB-1:0];
            end
        end else begin
            if (w_p > P_W'(FULL_M1)) begin
                n9_sample = FULL_M1;
                n9_sat    = 1'b1;
            end else begin
                n9_sample = w_p[SB-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_prod <= PRODM_W'(w_mag) * PRODM_W'(r_drive_gain);
            r1_neg  <= w_raw[SB-1];
        end
        if (w_en[2]) begin
            r2_m   <= w_m_rnd[GF +: M_W];
            r2_neg <= r1_neg;
        end
        if (w_en[3]) begin
            r_m_d[3]   <= r2_m;
            r_neg_d[3] <= r2_neg;
            r3_seg     <= n3_seg;
            r3_d       <= w_d[FB-1:0];
        end
        for (int i = 4; i <= 7; i++) begin
            if (w_en[i]) begin
                r_m_d[i]   <= r_m_d[i-1];
                r_neg_d[i] <= r_neg_d[i-1];
            end
        end
        if (w_en[4]) begin
            r4_seg <= r3_seg;
            r4_dd  <= DD_W'(r3_d) * DD_W'(r3_d);
        end
        if (w_en[5]) begin
            r5_seg <= r4_seg;
            r5_qr  <= QR_W'(w_dd_rnd[FB +: SB]) * QR_W'(QUAD_RECIP);
        end
        if (w_en[6]) begin
            r6_yq <= n6_yq;
        end
        if (w_en[7]) begin
            r7_yq <= r6_yq;
        end
        if (w_en[8]) begin
            r8_prod <= PRODL_W'(n8_y) * PRODL_W'(r_output_level);
            r8_yneg <= n8_yneg;
        end
        if (w_en[9]) begin
            r_out_sample <= n9_sample;
            r_out_sat    <= n9_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.saturated  = r_out_sat;

    // a clamped item carries one of the two full-scale codes
    a_sat_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.saturated |->
            (r_out_sample == FULL) || (r_out_sample == FULL_M1))
        else $error("saturated item without a full-scale value");

    // an accepted item lands in the first stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[1])
        else $error("accepted item lost at the first stage");

    // a blocked level stage keeps its item
    a_stage8_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8] && !w_en[9] |=> r_vld[8] && $stable(r8_prod) && $stable(r8_yneg))
        else $error("level stage changed while blocked");

endmodule
